### design/slb_pkg.sv
// shared types and constants for the sorted table lower bound search
// no dependencies; imported by the top level, the checker and the testbench top

package slb_pkg;

    // table geometry
    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int HI_W   = IDX_W + 1;
    localparam int DATA_W = 32;
    localparam int POS_W  = 11;

    // stream payload widths
    localparam int S_DATA_W = 32;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 16;

    localparam logic [HI_W-1:0] DEPTH_HI = HI_W'(DEPTH);

    // operation codes carried in the input tuser
    typedef enum logic [S_USER_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // search sequencer states
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_E0   = 7'b0000010,
        S_EXP  = 7'b0000100,
        S_BIN  = 7'b0001000,
        S_LO   = 7'b0010000,
        S_HI   = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

endpackage

### design/slb_ram.sv
// generic single write, single read port ram with registered read data
// no dependencies

module slb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/sorted_table_lower_bound_search.sv
// sorted table lower bound search: append, clear and exponential plus binary search
// clear and append are done as they are accepted; a query reads entry 0, then makes doubling
// probes (up to log2(DEPTH)), binary probes and one or two final checks, each a read of the
// table ram read port, before the result goes to the output register
// throughput: one query at a time; the input is held off while a search runs
// reset: clears entry count, overflow flag, sequencer and output valid; table ram is not cleared
// depends on slb_pkg and slb_ram

module sorted_table_lower_bound_search
    import slb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,  // [31:0] value
    input  logic [S_USER_W-1:0] i_s_axis_tuser,  // [1:0] action
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata   // [10:0] position, [11] dropped, [15:12] zero
);

    // control state
    t_state          r_state, n_state;
    logic [HI_W-1:0] r_cnt, n_cnt;
    logic            r_ovf, n_ovf;
    logic            r_out_valid, n_out_valid;

    // search payload
    logic signed [DATA_W-1:0] r_key, n_key;
    logic [HI_W-1:0]          r_lo, n_lo;
    logic [HI_W-1:0]          r_hi, n_hi;
    logic [HI_W-1:0]          r_res, n_res;
    logic [M_DATA_W-1:0]      r_out_data, n_out_data;

    // table ram ports
    logic              ram_we;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // search helpers
    logic            s_acc;
    logic            out_free;
    logic            probe_ge;
    logic            bin_go;
    logic [HI_W-1:0] b_lo, b_hi;
    logic [HI_W:0]   b_sum, cur_sum;
    logic [HI_W-1:0] b_mid, cur_mid;
    logic [HI_W-1:0] dbl;
    t_action         act;

    assign act             = t_action'(i_s_axis_tuser);
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign probe_ge        = $signed(ram_rdata) >= r_key;

    // midpoint of the current window and of the next one
    assign cur_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign cur_mid = cur_sum[HI_W:1];
    assign b_sum   = {1'b0, b_lo} + {1'b0, b_hi};
    assign b_mid   = b_sum[HI_W:1];
    assign dbl     = {r_hi[HI_W-2:0], 1'b0};

    slb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata (i_s_axis_tdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer: one table probe per cycle
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_key     = r_key;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        bin_go    = 1'b0;
        b_lo      = r_lo;
        b_hi      = r_hi;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    case (act)
                        ACT_CLEAR: begin
                            n_cnt = '0;
                            n_ovf = 1'b0;
                        end
                        ACT_APPEND: begin
                            if (r_cnt < DEPTH_HI) begin
                                ram_we = 1'b1;
                                n_cnt  = r_cnt + HI_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            n_key = $signed(i_s_axis_tdata);
                            if (r_cnt == '0) begin
                                n_res   = '0;
                                n_state = S_DONE;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                n_state   = S_E0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // entry 0 back from the ram
            S_E0: begin
                if (probe_ge) begin
                    b_hi   = '0;
                    bin_go = 1'b1;
                end else if (r_cnt > HI_W'(1)) begin
                    n_hi      = HI_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = IDX_W'(1);
                    n_state   = S_EXP;
                end else begin
                    b_hi   = r_cnt - HI_W'(1);
                    bin_go = 1'b1;
                end
                b_lo = b_hi >> 1;
            end
            // doubling probes
            S_EXP: begin
                if (probe_ge) begin
                    b_hi   = r_hi;
                    bin_go = 1'b1;
                end else if (dbl < r_cnt) begin
                    n_hi      = dbl;
                    ram_re    = 1'b1;
                    ram_raddr = dbl[IDX_W-1:0];
                end else begin
                    b_hi   = r_cnt - HI_W'(1);
                    bin_go = 1'b1;
                end
                b_lo = b_hi >> 1;
            end
            // binary probe at the window midpoint
            S_BIN: begin
                if (probe_ge) begin
                    b_lo = r_lo;
                    b_hi = cur_mid;
                end else begin
                    b_lo = cur_mid + HI_W'(1);
                    b_hi = r_hi;
                end
                bin_go = 1'b1;
            end
            // final check of the low end
            S_LO: begin
                if (probe_ge) begin
                    n_res   = r_lo;
                    n_state = S_DONE;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_hi[IDX_W-1:0];
                    n_state   = S_HI;
                end
            end
            // final check of the high end
            S_HI: begin
                n_res   = probe_ge ? r_hi : r_cnt;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // next window: probe its midpoint or move to the final checks
        if (bin_go) begin
            n_lo   = b_lo;
            n_hi   = b_hi;
            ram_re = 1'b1;
            if ((b_hi - b_lo) > HI_W'(1)) begin
                ram_raddr = b_mid[IDX_W-1:0];
                n_state   = S_BIN;
            end else begin
                ram_raddr = b_lo[IDX_W-1:0];
                n_state   = S_LO;
            end
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_DONE && out_free) begin
            n_out_valid = 1'b1;
            n_out_data  = M_DATA_W'({r_ovf, POS_W'(r_res)});
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

### sim/tb_search_checker.sv
`timescale 1ns / 100ps
// checker for the sorted table lower bound search: watches both stream channels,
// keeps its own table, predicts each query result and compares; depends on slb_pkg

module tb_search_checker
    import slb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // [31:0] value
    input  logic [S_USER_W-1:0] i_s_tuser,  // [1:0] action
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [M_DATA_W-1:0] i_m_tdata,  // [10:0] position, [11] dropped, [15:12] zero
    output int                  o_fail_count,
    output int                  o_pending
);

    typedef logic signed [DATA_W-1:0] t_entry;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             dropped;
    } t_search_result;

    // shadow copy of the block state
    t_entry tbl [DEPTH];
    int     entry_cnt;
    logic   overflow_seen;

    t_search_result expected_results [$];
    int             fail_cnt;

    // first index whose entry is >= key, following the doubling then halving probe order
    function automatic logic [POS_W-1:0] predict_position(input t_entry key);
        int n;
        int hi;
        int lo;
        int mid;
        n = entry_cnt;
        if (n == 0) return '0;
        // doubling probes
        if (tbl[0] >= key) begin
            hi = 0;
        end else begin
            hi = 1;
            while (hi < n && !(tbl[hi] >= key)) hi = hi << 1;
            if (hi >= n) hi = n - 1;
        end
        // halving probes from half the bound
        lo = hi >> 1;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (tbl[mid] >= key) hi = mid;
            else lo = mid + 1;
        end
        if (tbl[lo] >= key) return POS_W'(lo);
        if (tbl[hi] >= key) return POS_W'(hi);
        return POS_W'(n);
    endfunction

    // track input transactions, predict, and compare output transactions
    always @(posedge i_clk) begin : watch
        t_search_result exp_res;
        logic [POS_W-1:0] got_pos;
        logic             got_drop;
        if (!i_rst_n) begin
            entry_cnt     = 0;
            overflow_seen = 1'b0;
            expected_results.delete();
            fail_cnt      = 0;
        end else begin
            // result side
            if (i_m_tvalid && i_m_tready) begin
                got_pos  = i_m_tdata[POS_W-1:0];
                got_drop = i_m_tdata[POS_W];
                if (expected_results.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result, position %0d dropped %0b",
                             $time, got_pos, got_drop);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got_pos !== exp_res.position) begin
                        fail_cnt++;
                        $display("%0t: position expected %0d actual %0d",
                                 $time, exp_res.position, got_pos);
                    end
                    if (got_drop !== exp_res.dropped) begin
                        fail_cnt++;
                        $display("%0t: dropped expected %0b actual %0b",
                                 $time, exp_res.dropped, got_drop);
                    end
                end
            end
            // request side
            if (i_s_tvalid && i_s_tready) begin
                case (t_action'(i_s_tuser))
                    ACT_CLEAR: begin
                        entry_cnt     = 0;
                        overflow_seen = 1'b0;
                    end
                    ACT_APPEND: begin
                        if (entry_cnt < DEPTH) begin
                            tbl[entry_cnt] = t_entry'(i_s_tdata);
                            entry_cnt++;
                        end else begin
                            overflow_seen = 1'b1;
                        end
                    end
                    ACT_QUERY: begin
                        exp_res.position = predict_position(t_entry'(i_s_tdata));
                        exp_res.dropped  = overflow_seen;
                        expected_results.push_back(exp_res);
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_results.size();
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the sorted table lower bound search: clock, reset, request stimulus,
// result back-pressure and verdict; depends on slb_pkg, the block and tb_search_checker

module tb_top
    import slb_pkg::*;
();

    localparam int ITEM_TARGET = 1300;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int fail_cnt;
    int pending;
    int n_items    = 0;
    int burst_left = 0;
    int cycles     = 0;

    sorted_table_lower_bound_search u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    tb_search_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_cnt),
        .o_pending    (pending)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("sorted_table_lower_bound_search: mismatch");
        $finish;
    end

    // one request transaction, sent in bursts with random gaps in between
    task automatic send_item(input t_action act, input logic [31:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= act;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        burst_left--;
        if (act != ACT_NONE) n_items++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // query key: mostly near stored entries, sometimes anywhere or at the extremes
    function automatic logic [31:0] pick_key(ref logic [31:0] vals [$]);
        int r;
        int idx;
        r = $urandom_range(0, 99);
        if (vals.size() == 0 || r < 15) return $urandom;
        idx = $urandom_range(0, vals.size() - 1);
        if (r < 55) return vals[idx];
        if (r < 70) return vals[idx] + 32'd1;
        if (r < 85) return vals[idx] - 32'd1;
        if (r < 92) return 32'h8000_0000;
        return 32'h7fff_ffff;
    endfunction

    // load a table (ordered or not) then query it; queries also land while it grows
    task automatic build_and_query(input bit ordered, input int n_entries, input int n_queries,
                                   input bit start_clear, input int mode_sel);
        logic [31:0] vals [$];
        longint      v;
        longint      step_max;
        int          mode;
        int          i;
        mode = (mode_sel < 0) ? $urandom_range(0, 2) : mode_sel;
        case (mode)
            0:       begin v = longint'($urandom_range(0, 40)) - 20; step_max = 2; end
            1:       begin v = longint'($signed($urandom)); step_max = 1 << 24; end
            default: begin v = -64'sd2147483648; step_max = 1 << 30; end
        endcase
        if (start_clear) send_item(ACT_CLEAR, $urandom);
        for (i = 0; i < n_entries; i++) begin
            if (ordered) begin
                v = v + longint'($urandom_range(0, 32'(step_max)));
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                vals.push_back(32'(v));
            end else begin
                vals.push_back((mode == 0) ? 32'($urandom_range(0, 15)) - 32'd8 : $urandom);
            end
            send_item(ACT_APPEND, vals[vals.size() - 1]);
            if ($urandom_range(0, 99) < 15) send_item(ACT_QUERY, pick_key(vals));
        end
        for (i = 0; i < n_queries; i++) send_item(ACT_QUERY, pick_key(vals));
    endtask

    // random mix of every action, ignored ones included
    task automatic send_noise(input int n);
        int i;
        int r;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10)      send_item(ACT_CLEAR, $urandom);
            else if (r < 50) send_item(ACT_APPEND, $urandom);
            else if (r < 85) send_item(ACT_QUERY, $urandom);
            else             send_item(ACT_NONE, $urandom);
        end
    endtask

    // result side back-pressure: segments of differing stall patterns, one long hold-off
    initial begin : rx_pattern
        int  seg;
        int  mode;
        int  k;
        bit  hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && n_items >= HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(16, 128);
            for (k = 0; k < seg; k++) begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= ((k % 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // reset, directed cases, random scenarios, verdict
    initial begin : stimulus
        int scen;
        int r;
        int n_entries;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, extremes, duplicates and ignored action
        send_item(ACT_QUERY,  32'd0);
        send_item(ACT_NONE,   32'hffff_ffff);
        send_item(ACT_APPEND, 32'h8000_0000);
        send_item(ACT_QUERY,  32'h8000_0000);
        send_item(ACT_QUERY,  32'h7fff_ffff);
        send_item(ACT_APPEND, 32'hffff_ffff);
        send_item(ACT_APPEND, 32'd0);
        send_item(ACT_APPEND, 32'd0);
        send_item(ACT_APPEND, 32'h7fff_ffff);
        send_item(ACT_QUERY,  32'd0);
        send_item(ACT_QUERY,  32'hffff_ffff);
        send_item(ACT_QUERY,  32'h7fff_ffff);
        send_item(ACT_QUERY,  32'd1);
        send_item(ACT_QUERY,  32'h8000_0000);
        send_item(ACT_NONE,   32'd0);
        // clear then query the empty table
        send_item(ACT_CLEAR,  32'd0);
        send_item(ACT_QUERY,  32'd5);
        // unsorted table
        send_item(ACT_APPEND, 32'd10);
        send_item(ACT_APPEND, 32'd3);
        send_item(ACT_APPEND, 32'd7);
        send_item(ACT_QUERY,  32'd5);
        send_item(ACT_QUERY,  32'd8);
        send_item(ACT_QUERY,  32'd11);
        send_item(ACT_CLEAR,  32'hffff_ffff);
        drain();

        // random scenarios; the full table case comes early, then a pause until every result is back
        scen = 0;
        while (n_items < ITEM_TARGET) begin
            if (scen == 3) begin
                build_and_query(1'b1, DEPTH + 3, 24, 1'b1, 0);
                send_item(ACT_QUERY, 32'h7fff_ffff);
                drain();
            end else begin
                r = $urandom_range(0, 99);
                n_entries = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 80)
                                                         : $urandom_range(0, 16);
                if (r < 65)
                    build_and_query(1'b1, n_entries, $urandom_range(1, 10),
                                    $urandom_range(0, 5) != 0, -1);
                else if (r < 80)
                    build_and_query(1'b0, n_entries, $urandom_range(1, 10), 1'b1, -1);
                else
                    send_noise($urandom_range(4, 12));
            end
            scen++;
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
        if (fail_cnt == 0 && pending == 0)
            $display("sorted_table_lower_bound_search: match");
        else
            $display("sorted_table_lower_bound_search: mismatch");
        $finish;
    end

endmodule
